/* src/assert_macros.svh */
// assertion macros shared by the fire store modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FSFS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("fire store assertion failed");
`define FSFS_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("fire store forbidden condition seen");
`else
`define FSFS_ASSERT(label, prop)
`define FSFS_NEVER(label, expr)
`endif
`endif

/* src/fsfs_pkg.sv */
// shared types, constants and palette for the fire spread frame store
package fsfs_pkg;

	localparam int FRAME_WIDTH     = 320;
	localparam int FRAME_HEIGHT    = 200;
	localparam int PALETTE_ENTRIES = 37;

	localparam int STORE_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int INT_W       = 6;
	localparam int COLOR_W     = 24;
	localparam int COL_W       = 9;
	localparam int ROW_W       = 8;
	localparam int RAND_W      = 2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int BOTTOM_BASE = (FRAME_HEIGHT - 1) * FRAME_WIDTH;

	localparam logic OP_SPREAD = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam int PALETTE_DEPTH = 37;

	typedef struct packed {
		logic              is_read;
		logic              ok;
		logic              decay;
		logic [ADDR_W-1:0] src_addr;
		logic [ADDR_W-1:0] dst_addr;
	} fsfs_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fsfs_qstat_t;

	function automatic logic [COLOR_W-1:0] fsfs_palette(input logic [INT_W-1:0] level);
		logic [COLOR_W-1:0] c;
		case (level)
			6'd0:  c = 24'h070707;
			6'd1:  c = 24'h1F0707;
			6'd2:  c = 24'h2F0F07;
			6'd3:  c = 24'h470F07;
			6'd4:  c = 24'h571707;
			6'd5:  c = 24'h671F07;
			6'd6:  c = 24'h771F07;
			6'd7:  c = 24'h8F2707;
			6'd8:  c = 24'h9F2F07;
			6'd9:  c = 24'hAF3F07;
			6'd10: c = 24'hBF4707;
			6'd11: c = 24'hC74707;
			6'd12: c = 24'hDF4F07;
			6'd13: c = 24'hDF5707;
			6'd14: c = 24'hDF5707;
			6'd15: c = 24'hD75F07;
			6'd16: c = 24'hD75F07;
			6'd17: c = 24'hD7670F;
			6'd18: c = 24'hCF6F0F;
			6'd19: c = 24'hCF770F;
			6'd20: c = 24'hCF7F0F;
			6'd21: c = 24'hCF8717;
			6'd22: c = 24'hC78717;
			6'd23: c = 24'hC78F17;
			6'd24: c = 24'hC7971F;
			6'd25: c = 24'hBF9F1F;
			6'd26: c = 24'hBF9F1F;
			6'd27: c = 24'hBFA727;
			6'd28: c = 24'hBFA727;
			6'd29: c = 24'hBFAF2F;
			6'd30: c = 24'hB7AF2F;
			6'd31: c = 24'hB7B72F;
			6'd32: c = 24'hB7B737;
			6'd33: c = 24'hCFCF6F;
			6'd34: c = 24'hDFDF9F;
			6'd35: c = 24'hEFEFC7;
			default: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

endpackage

/* src/fsfs_front.sv */
// front end: takes a command word, checks bounds and works out store addresses
module fsfs_front
	import fsfs_pkg::*;
(
	input  logic              operation,
	input  logic [COL_W-1:0]  column,
	input  logic [ROW_W-1:0]  row,
	input  logic [RAND_W-1:0] random_value,
	output fsfs_item_t        item
);

	logic              in_frame;
	logic [31:0]       shifted;
	logic              dst_ok;
	logic [ADDR_W-1:0] src_addr;

	always_comb begin
		in_frame = (32'(column) < 32'(FRAME_WIDTH)) && (32'(row) < 32'(FRAME_HEIGHT));
		// destination column plus two, kept unsigned
		shifted  = 32'(column) + 32'd3 - 32'(random_value);
		dst_ok   = (shifted >= 32'd2) && ((shifted - 32'd2) < 32'(FRAME_WIDTH));
		src_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(FRAME_WIDTH)) + ADDR_W'(column);

		item.is_read  = (operation == OP_READ);
		item.ok       = (operation == OP_READ) ? in_frame
			: (in_frame && (row != '0) && dst_ok);
		item.decay    = random_value[0];
		item.src_addr = src_addr;
		// one row up, shifted by one minus the random value
		item.dst_addr = ADDR_W'(32'(src_addr) - 32'(FRAME_WIDTH) + 32'd1
			- 32'(random_value));
	end

endmodule

/* src/fsfs_queue.sv */
// short fifo between the front end and the store pipeline
`include "assert_macros.svh"
module fsfs_queue
	import fsfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  fsfs_item_t  push_item,
	input  logic        pop,
	output fsfs_item_t  head,
	output fsfs_qstat_t stat
);

	fsfs_item_t        entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	assign head       = entry_q[rd_ptr_q];
	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

	`FSFS_NEVER(a_no_push_full, push && stat.full)
	`FSFS_NEVER(a_no_pop_empty, pop && stat.empty)
	`FSFS_ASSERT(a_count_bound, count_q <= QCNT_W'(QUEUE_DEPTH))

endmodule

/* src/fsfs_back.sv */
// back end: frame store memory, clearing sweep, read-modify-write and result stage
`include "assert_macros.svh"
module fsfs_back
	import fsfs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  fsfs_item_t         head,
	output logic               pop,
	output logic               clearing,
	output logic               strobe,
	output logic               written,
	output logic [INT_W-1:0]   intensity,
	output logic [COLOR_W-1:0] color
);

	logic [INT_W-1:0]  store_mem [STORE_DEPTH];
	logic [INT_W-1:0]  rd_data_q;

	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic              valid_s1;
	fsfs_item_t        item_s1;
	logic              fwd_hit_s1;
	logic [INT_W-1:0]  fwd_data_s1;

	logic               strobe_s2;
	logic               written_s2;
	logic [INT_W-1:0]   intensity_s2;
	logic [COLOR_W-1:0] color_s2;

	logic               mem_we;
	logic [ADDR_W-1:0]  mem_wa;
	logic [INT_W-1:0]   mem_wd;
	logic               item_we;
	logic [INT_W-1:0]   src_val;
	logic [INT_W-1:0]   new_val;
	logic               res_written;
	logic [INT_W-1:0]   res_intensity;
	logic [COLOR_W-1:0] res_color;

	assign pop      = q_valid && !clearing_q;
	assign clearing = clearing_q;

	always_comb begin
		item_we = valid_s1 && !item_s1.is_read && item_s1.ok;
		src_val = fwd_hit_s1 ? fwd_data_s1 : rd_data_q;
		new_val = (src_val > INT_W'(item_s1.decay)) ? src_val - INT_W'(item_s1.decay) : '0;

		if (clearing_q) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = (32'(clr_addr_q) >= 32'(BOTTOM_BASE)) ? INT_W'(PALETTE_ENTRIES - 1) : '0;
		end else begin
			mem_we = item_we;
			mem_wa = item_s1.dst_addr;
			mem_wd = new_val;
		end

		res_written   = 1'b0;
		res_intensity = '0;
		res_color     = '0;
		if (item_s1.is_read) begin
			if (item_s1.ok) begin
				res_intensity = src_val;
				res_color     = fsfs_palette(src_val);
			end
		end else if (item_s1.ok) begin
			res_written   = 1'b1;
			res_intensity = new_val;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			store_mem[mem_wa] <= mem_wd;
		if (pop)
			rd_data_q <= store_mem[head.src_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			valid_s1   <= 1'b0;
			strobe_s2  <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
				if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1))
					clearing_q <= 1'b0;
			end
			valid_s1  <= pop;
			strobe_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1     <= head;
			// same-edge write hides from the read port, so pass it along
			fwd_hit_s1  <= item_we && (item_s1.dst_addr == head.src_addr);
			fwd_data_s1 <= new_val;
		end
		written_s2   <= res_written;
		intensity_s2 <= res_intensity;
		color_s2     <= res_color;
	end

	assign strobe    = strobe_s2;
	assign written   = written_s2;
	assign intensity = intensity_s2;
	assign color     = color_s2;

	`FSFS_NEVER(a_no_item_while_clearing, clearing_q && valid_s1)
	`FSFS_ASSERT(a_result_follows, valid_s1 |=> strobe_s2)
	`FSFS_ASSERT(a_result_only_from_item, strobe_s2 |-> $past(valid_s1))
	`FSFS_NEVER(a_written_read_mix, strobe_s2 && written_s2 && (color_s2 != '0))

endmodule

/* src/fire_spread_frame_store_core.sv */
// top level of the fire spread frame store
//
// channel   direction  handshake                 word
// command   in         start, busy               operation, column, row, random_value
// result    out        strobe (one cycle)        written, intensity, color
//
// one word per clock in while busy is low and one result per clock out; a result
// leaves through the queue write, store read and result register
// after reset the store is swept one entry a cycle, clearing the frame and
// setting the bottom row to full heat; busy is high throughout
// busy is also high while the queue is full; results cannot be held off
// a spread reading a pixel written by the word just ahead gets it by forwarding
module fire_spread_frame_store_core
	import fsfs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [COL_W-1:0]   column,
	input  logic [ROW_W-1:0]   row,
	input  logic [RAND_W-1:0]  random_value,
	output logic               strobe,
	output logic               written,
	output logic [INT_W-1:0]   intensity,
	output logic [COLOR_W-1:0] color
);

	fsfs_item_t  front_item;   // classified command word
	fsfs_item_t  head_item;    // oldest queued word
	fsfs_qstat_t q_stat;
	logic        push;
	logic        pop;
	logic        clearing;

	// a command is taken whenever start meets a low busy
	assign push = start && !busy;
	assign busy = clearing || q_stat.full;

	fsfs_front u_front (
		.operation    (operation),
		.column       (column),
		.row          (row),
		.random_value (random_value),
		.item         (front_item)
	);

	fsfs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.head      (head_item),
		.stat      (q_stat)
	);

	// store pipeline drains the queue one word a cycle once the clearing sweep is done
	fsfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (!q_stat.empty),
		.head      (head_item),
		.pop       (pop),
		.clearing  (clearing),
		.strobe    (strobe),
		.written   (written),
		.intensity (intensity),
		.color     (color)
	);

endmodule

/* verif/tb.sv */
// self-checking testbench for the fire spread frame store core
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fsfs_pkg::*;

	// a store sweep after reset writes every store entry with busy high, so the
	// watchdog waits for longer than the store depth before it calls the run dead
	localparam int WATCHDOG_LIMIT = 200000;
	// extra idle time after the last owed result, so a stray result is still seen
	localparam int DRAIN_CYCLES   = 8;
	localparam int RANDOM_WORDS   = 1150;
	// no idling over the last stretch of the random part
	localparam int QUIET_TAIL     = 150;
	localparam int HOT_KEEP       = 24;
	localparam int DIRECTED_COUNT = 25;

	// fire palette, index 0 is the coolest ember and the last entry is white heat
	localparam logic [COLOR_W-1:0] FIRE_RGB [PALETTE_DEPTH] = '{
		24'h070707, 24'h1F0707, 24'h2F0F07, 24'h470F07, 24'h571707, 24'h671F07,
		24'h771F07, 24'h8F2707, 24'h9F2F07, 24'hAF3F07, 24'hBF4707, 24'hC74707,
		24'hDF4F07, 24'hDF5707, 24'hDF5707, 24'hD75F07, 24'hD75F07, 24'hD7670F,
		24'hCF6F0F, 24'hCF770F, 24'hCF7F0F, 24'hCF8717, 24'hC78717, 24'hC78F17,
		24'hC7971F, 24'hBF9F1F, 24'hBF9F1F, 24'hBFA727, 24'hBFA727, 24'hBFAF2F,
		24'hB7AF2F, 24'hB7B72F, 24'hB7B737, 24'hCFCF6F, 24'hDFDF9F, 24'hEFEFC7,
		24'hFFFFFF
	};

	// one command word, plus an optional typed-in result
	typedef struct packed {
		logic               op;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   rw;
		logic [RAND_W-1:0]  rnd;
		logic               chk;
		logic               wr;
		logic [INT_W-1:0]   lvl;
		logic [COLOR_W-1:0] rgb;
	} fire_cmd_t;

	typedef struct packed {
		logic               wr;
		logic [INT_W-1:0]   lvl;
		logic [COLOR_W-1:0] rgb;
	} fire_result_t;

	// directed words: extreme reads, off-frame reads, spreads that store nothing,
	// then real spreads with back-to-back hazards on the pixel just written
	localparam fire_cmd_t DIRECTED_WORDS [DIRECTED_COUNT] = '{
		// reads straight after the sweep: bottom row at full heat, rest cold
		'{OP_READ,   9'd0,   8'd199, 2'd0, 1'b1, 1'b0, 6'd36, 24'hFFFFFF},
		'{OP_READ,   9'd319, 8'd199, 2'd3, 1'b1, 1'b0, 6'd36, 24'hFFFFFF},
		'{OP_READ,   9'd0,   8'd0,   2'd0, 1'b1, 1'b0, 6'd0,  24'h070707},
		'{OP_READ,   9'd319, 8'd198, 2'd1, 1'b1, 1'b0, 6'd0,  24'h070707},
		// reads outside the frame give all zero
		'{OP_READ,   9'd320, 8'd10,  2'd2, 1'b1, 1'b0, 6'd0,  24'h000000},
		'{OP_READ,   9'd511, 8'd255, 2'd3, 1'b1, 1'b0, 6'd0,  24'h000000},
		'{OP_READ,   9'd5,   8'd200, 2'd0, 1'b1, 1'b0, 6'd0,  24'h000000},
		// spreads that store nothing: top row, off screen either side, off frame
		'{OP_SPREAD, 9'd7,   8'd0,   2'd0, 1'b1, 1'b0, 6'd0,  24'h000000},
		'{OP_SPREAD, 9'd319, 8'd199, 2'd0, 1'b1, 1'b0, 6'd0,  24'h000000},
		'{OP_SPREAD, 9'd0,   8'd199, 2'd3, 1'b1, 1'b0, 6'd0,  24'h000000},
		'{OP_SPREAD, 9'd0,   8'd199, 2'd2, 1'b1, 1'b0, 6'd0,  24'h000000},
		'{OP_SPREAD, 9'd511, 8'd255, 2'd1, 1'b1, 1'b0, 6'd0,  24'h000000},
		'{OP_SPREAD, 9'd100, 8'd250, 2'd0, 1'b1, 1'b0, 6'd0,  24'h000000},
		// full heat shifted right, then carried up twice back to back
		'{OP_SPREAD, 9'd10,  8'd199, 2'd0, 1'b1, 1'b1, 6'd36, 24'h000000},
		'{OP_SPREAD, 9'd11,  8'd198, 2'd1, 1'b0, 1'b0, 6'd0,  24'h000000},
		'{OP_SPREAD, 9'd11,  8'd197, 2'd1, 1'b0, 1'b0, 6'd0,  24'h000000},
		'{OP_READ,   9'd11,  8'd196, 2'd0, 1'b0, 1'b0, 6'd0,  24'h000000},
		// decay by one or none, both frame edges
		'{OP_SPREAD, 9'd10,  8'd199, 2'd1, 1'b1, 1'b1, 6'd35, 24'h000000},
		'{OP_SPREAD, 9'd0,   8'd199, 2'd1, 1'b1, 1'b1, 6'd35, 24'h000000},
		'{OP_SPREAD, 9'd319, 8'd199, 2'd2, 1'b1, 1'b1, 6'd36, 24'h000000},
		'{OP_SPREAD, 9'd319, 8'd199, 2'd3, 1'b1, 1'b1, 6'd35, 24'h000000},
		// decay of a cold pixel stays at zero but is still written
		'{OP_SPREAD, 9'd50,  8'd100, 2'd1, 1'b1, 1'b1, 6'd0,  24'h000000},
		// write into the top row at the last column
		'{OP_SPREAD, 9'd318, 8'd1,   2'd0, 1'b1, 1'b1, 6'd0,  24'h000000},
		'{OP_READ,   9'd318, 8'd198, 2'd2, 1'b0, 1'b0, 6'd0,  24'h000000},
		'{OP_READ,   9'd317, 8'd198, 2'd1, 1'b0, 1'b0, 6'd0,  24'h000000}
	};

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               operation;
	logic [COL_W-1:0]   column;
	logic [ROW_W-1:0]   row;
	logic [RAND_W-1:0]  random_value;
	logic               strobe;
	logic               written;
	logic [INT_W-1:0]   intensity;
	logic [COLOR_W-1:0] color;

	// own copy of the frame, results still owed, recent hot pixels
	logic [INT_W-1:0] heat_map [STORE_DEPTH];
	fire_result_t     pending_results [$];
	fire_result_t     oldest;
	int               hot_x [$];
	int               hot_y [$];
	int               mismatches   = 0;
	int               quiet_cycles = 0;

	fire_spread_frame_store_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.column       (column),
		.row          (row),
		.random_value (random_value),
		.strobe       (strobe),
		.written      (written),
		.intensity    (intensity),
		.color        (color)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// works out what one word gives and updates the frame copy
	function automatic fire_result_t spread_or_read(input fire_cmd_t w);
		fire_result_t res;
		int           x;
		int           y;
		int           dst;
		int           lvl;
		int           decay;
		logic         on_frame;
		res      = '0;
		x        = int'(w.col);
		y        = int'(w.rw);
		on_frame = (x < FRAME_WIDTH) && (y < FRAME_HEIGHT);
		if (w.op == OP_READ) begin
			if (on_frame) begin
				lvl     = int'(heat_map[y * FRAME_WIDTH + x]);
				res.lvl = lvl[INT_W-1:0];
				res.rgb = (lvl >= PALETTE_DEPTH) ? FIRE_RGB[PALETTE_DEPTH-1] : FIRE_RGB[lvl];
			end
		end else if (on_frame && y != 0) begin
			// heat drifts sideways by one minus the random value and cools by its low bit
			dst = x + 1 - int'(w.rnd);
			if (dst >= 0 && dst < FRAME_WIDTH) begin
				lvl   = int'(heat_map[y * FRAME_WIDTH + x]);
				decay = int'(w.rnd[0]);
				lvl   = (lvl > decay) ? lvl - decay : 0;
				heat_map[(y - 1) * FRAME_WIDTH + dst] = lvl[INT_W-1:0];
				res.wr  = 1'b1;
				res.lvl = lvl[INT_W-1:0];
			end
		end
		return res;
	endfunction

	// offers one word and waits until it is taken
	task automatic send_word(input fire_cmd_t w);
		fire_result_t res;
		start        <= 1'b1;
		operation    <= w.op;
		column       <= w.col;
		row          <= w.rw;
		random_value <= w.rnd;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		res = spread_or_read(w);
		pending_results.push_back(w.chk ? fire_result_t'({w.wr, w.lvl, w.rgb}) : res);
		// remember where fresh heat landed so later words can carry it further up
		if (w.op == OP_SPREAD && res.wr) begin
			hot_x.push_back(int'(w.col) + 1 - int'(w.rnd));
			hot_y.push_back(int'(w.rw) - 1);
			if (hot_x.size() > HOT_KEEP) begin
				void'(hot_x.pop_front());
				void'(hot_y.pop_front());
			end
		end
	endtask

	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles)
			@(posedge clk);
	endtask

	// sender stands back until every owed result has come out
	task automatic wait_drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	initial begin : stimulus
		fire_cmd_t w;
		int        pick;
		int        k;
		start        <= 1'b0;
		operation    <= OP_SPREAD;
		column       <= '0;
		row          <= '0;
		random_value <= '0;
		arst_n       <= 1'b0;
		// frame copy after the sweep: cold everywhere, bottom row at full heat
		for (int i = 0; i < STORE_DEPTH; i++)
			heat_map[i] = '0;
		for (int i = 0; i < FRAME_WIDTH; i++)
			heat_map[BOTTOM_BASE + i] = INT_W'(PALETTE_ENTRIES - 1);
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words go back to back to hit the forwarding path
		for (int i = 0; i < DIRECTED_COUNT; i++)
			send_word(DIRECTED_WORDS[i]);
		wait_drain();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			w     = '0;
			pick  = $urandom_range(0, 99);
			w.rnd = RAND_W'($urandom_range(0, 3));
			if (pick < 8) begin
				// noise over the whole field range, off-frame included
				w.op  = 1'($urandom_range(0, 1));
				w.col = COL_W'($urandom_range(0, 511));
				w.rw  = ROW_W'($urandom_range(0, 255));
			end else if (pick < 30) begin
				w.op = OP_READ;
				if (hot_x.size() != 0 && pick < 24) begin
					k     = $urandom_range(0, hot_x.size() - 1);
					w.col = COL_W'(hot_x[k]);
					w.rw  = ROW_W'(hot_y[k]);
				end else begin
					w.col = COL_W'($urandom_range(0, FRAME_WIDTH - 1));
					w.rw  = ROW_W'($urandom_range(0, FRAME_HEIGHT - 1));
				end
			end else begin
				w.op = OP_SPREAD;
				if (hot_x.size() != 0 && pick < 70) begin
					// carry recent heat further up the frame
					k     = $urandom_range(0, hot_x.size() - 1);
					w.col = COL_W'(hot_x[k]);
					w.rw  = ROW_W'(hot_y[k]);
				end else if (pick < 92) begin
					w.col = COL_W'($urandom_range(0, FRAME_WIDTH - 1));
					w.rw  = ROW_W'(FRAME_HEIGHT - 1 - int'($urandom_range(0, 2)));
				end else begin
					w.col = COL_W'($urandom_range(0, FRAME_WIDTH - 1));
					w.rw  = ROW_W'($urandom_range(0, FRAME_HEIGHT - 1));
				end
			end
			send_word(w);
			if (i == 400 || i == 800)
				wait_drain();
			else if (i < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 6) == 0)
				hold_off($urandom_range(1, 12));
		end

		wait_drain();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// each strobed result is matched against the oldest owed result
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, written %0b intensity %0d color %06h",
					$time, written, intensity, color);
				mismatches++;
			end else begin
				oldest = pending_results.pop_front();
				if (written !== oldest.wr) begin
					$display("%0t: written expected %0b actual %0b", $time, oldest.wr, written);
					mismatches++;
				end
				if (intensity !== oldest.lvl) begin
					$display("%0t: intensity expected %0d actual %0d",
						$time, oldest.lvl, intensity);
					mismatches++;
				end
				if (color !== oldest.rgb) begin
					$display("%0t: color expected %06h actual %06h", $time, oldest.rgb, color);
					mismatches++;
				end
			end
		end
	end

	// watchdog: too long with no word taken and no result seen
	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule
